// ===== rtl/core/ffmt_pkg.sv =====
// ============================================================================
// ffmt_pkg: shared types and constants of the LED frame formatter
// Item layouts, opcode and command byte values, the digit segment table and
// the job record that travels from the front end to the byte sequencer.
// ============================================================================
package ffmt_pkg;

    // Request opcodes.
    localparam logic [2:0] OP_UNSIGNED = 3'd0;
    localparam logic [2:0] OP_TIME     = 3'd1;
    localparam logic [2:0] OP_COLON    = 3'd2;
    localparam logic [2:0] OP_SIGNED   = 3'd3;
    localparam logic [2:0] OP_OFF      = 3'd4;
    localparam logic [2:0] OP_BRIGHT   = 3'd5;
    localparam logic [2:0] OP_INIT     = 3'd6;

    // Driver command bytes and special segment patterns.
    localparam logic [7:0] ADDR_CMD  = 8'hC0;
    localparam logic [7:0] DATA_CMD  = 8'h40;
    localparam logic [7:0] DISP_CMD  = 8'h80;
    localparam logic [7:0] DISP_ON   = 8'h08;
    localparam logic [7:0] DASH_SEG  = 8'h40;
    localparam logic [7:0] BLANK_SEG = 8'h00;
    localparam logic [7:0] POINT_BIT = 8'h80;

    // Saturation limits and the reset brightness.
    localparam logic [15:0] MAX_UNSIGNED = 16'd9999;
    localparam logic [15:0] MAX_NEG_MAG  = 16'd999;
    localparam logic [15:0] MAX_LEVEL    = 16'd7;
    localparam logic [2:0]  RESET_LEVEL  = 3'd2;

    // Reciprocal multipliers: floor(x * K >> S) equals x / D over each range.
    localparam int MUL_DIV1000 = 8389;   // x < 10000, shift 23
    localparam int MUL_DIV100  = 41;     // x < 1000, shift 12
    localparam int MUL_DIV10   = 205;    // x < 100, shift 11

    // Depth of the job queue between the front end and the sequencer.
    localparam int FFMT_QUEUE_DEPTH = 2;

    // Segment patterns of digits 0 to 9, bit0 = a up to bit6 = g.
    localparam logic [9:0][7:0] DIGIT_SEG = {
        8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] wire_byte;
        logic       frame_start;
        logic       frame_end;
        logic       last;
    } t_out_item;

    // How a request is rendered once it leaves the first stage.
    typedef enum logic [1:0] {
        KIND_DIGITS,
        KIND_SIGNED,
        KIND_CMD1,
        KIND_CMD2
    } t_kind;

    // One front pipeline stage: digits are peeled off the remainder x.
    typedef struct packed {
        t_kind       kind;
        logic        point;
        logic        neg;
        logic [13:0] x;
        logic [3:0]  d3;
        logic [3:0]  d2;
        logic [3:0]  d1;
        logic [7:0]  cmd0;
        logic [7:0]  cmd1;
    } t_fstage;

    // A finished job: up to five bytes with their frame marks.
    typedef struct packed {
        logic [2:0]      last_idx;
        logic [4:0][7:0] bytes;
        logic [4:0]      start_mask;
        logic [4:0]      end_mask;
    } t_job;

    function automatic logic [7:0] seg_of(input logic [3:0] d);
        logic [7:0] s;
        s = BLANK_SEG;
        if (d <= 4'd9) begin
            s = DIGIT_SEG[d];
        end
        return s;
    endfunction

endpackage

// ===== rtl/core/ffmt_front.sv =====
// ============================================================================
// ffmt_front: request intake, classification and digit extraction
// Accepts requests, keeps the brightness level, saturates the number and
// peels off one decimal digit per stage before building a job record.
// ============================================================================
module ffmt_front
    import ffmt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_data,
    output logic      o_stall,
    output logic      o_push,
    output t_job      o_job,
    input  logic      i_full
);

    logic       r_v1, r_v2, r_v3, r_v4;
    logic       n_v1, n_v2, n_v3, n_v4;
    t_fstage    r_s1, r_s2, r_s3, r_s4;
    t_fstage    n_s1, n_s2, n_s3, n_s4;
    logic [2:0] r_level, n_level;

    logic w_adv1, w_adv2, w_adv3, w_adv4;
    logic w_can1, w_can2, w_can3, w_can4;
    logic w_accept, w_keep;

    logic [15:0] w_negmag;
    logic [15:0] w_mag;
    logic [2:0]  w_new_level;
    logic [27:0] w_p3;
    logic [15:0] w_p2;
    logic [14:0] w_p1;
    logic [3:0]  w_d3, w_d2, w_d1, w_d0;
    logic [3:0][7:0] w_seg;

    // Stage handshake: a stage moves when the one after it can take it.
    assign w_adv4   = r_v4 && !i_full;
    assign w_can4   = !r_v4 || w_adv4;
    assign w_adv3   = r_v3 && w_can4;
    assign w_can3   = !r_v3 || w_adv3;
    assign w_adv2   = r_v2 && w_can3;
    assign w_can2   = !r_v2 || w_adv2;
    assign w_adv1   = r_v1 && w_can2;
    assign w_can1   = !r_v1 || w_adv1;
    assign o_stall  = !w_can1;
    assign w_accept = i_valid && w_can1;
    assign o_push   = w_adv4;

    // Classify the incoming item and saturate its number.
    always_comb begin
        w_negmag    = ~i_data.value + 16'd1;
        w_new_level = (i_data.value > MAX_LEVEL) ? 3'd7 : i_data.value[2:0];
        w_mag       = (i_data.value > MAX_UNSIGNED) ? MAX_UNSIGNED : i_data.value;
        w_keep      = 1'b1;
        n_level     = r_level;
        n_s1        = '0;
        n_s1.kind   = KIND_DIGITS;
        unique case (i_data.op)
            OP_UNSIGNED: begin
                n_s1.x = w_mag[13:0];
            end
            OP_TIME, OP_COLON: begin
                n_s1.x     = w_mag[13:0];
                n_s1.point = 1'b1;
            end
            OP_SIGNED: begin
                n_s1.kind = KIND_SIGNED;
                n_s1.neg  = i_data.value[15];
                if (i_data.value[15]) begin
                    n_s1.x = (w_negmag > MAX_NEG_MAG) ? MAX_NEG_MAG[13:0] : w_negmag[13:0];
                end else begin
                    n_s1.x = w_mag[13:0];
                end
            end
            OP_OFF: begin
                n_s1.kind = KIND_CMD1;
                n_s1.cmd0 = DISP_CMD | {5'd0, r_level};
            end
            OP_BRIGHT: begin
                n_s1.kind = KIND_CMD1;
                n_s1.cmd0 = DISP_CMD | DISP_ON | {5'd0, w_new_level};
                if (w_accept) begin
                    n_level = w_new_level;
                end
            end
            OP_INIT: begin
                n_s1.kind = KIND_CMD2;
                n_s1.cmd0 = DATA_CMD;
                n_s1.cmd1 = DISP_CMD | DISP_ON | {5'd0, r_level};
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    // Thousands digit from the saturated value.
    always_comb begin
        w_p3    = 28'(r_s1.x) * 28'(MUL_DIV1000);
        w_d3    = w_p3[26:23];
        n_s2    = r_s1;
        n_s2.d3 = w_d3;
        n_s2.x  = r_s1.x - 14'(14'(w_d3) * 14'd1000);
    end

    // Hundreds digit from the remainder below one thousand.
    always_comb begin
        w_p2    = 16'(r_s2.x[9:0]) * 16'(MUL_DIV100);
        w_d2    = w_p2[15:12];
        n_s3    = r_s2;
        n_s3.d2 = w_d2;
        n_s3.x  = r_s2.x - 14'(14'(w_d2) * 14'd100);
    end

    // Tens digit; the units digit is what remains.
    always_comb begin
        w_p1    = 15'(r_s3.x[6:0]) * 15'(MUL_DIV10);
        w_d1    = w_p1[14:11];
        n_s4    = r_s3;
        n_s4.d1 = w_d1;
        n_s4.x  = r_s3.x - 14'(14'(w_d1) * 14'd10);
    end

    // Segment patterns with point, blanking and dash placement.
    always_comb begin
        w_d0     = r_s4.x[3:0];
        w_seg[3] = seg_of(r_s4.d3);
        w_seg[2] = seg_of(r_s4.d2) | (r_s4.point ? POINT_BIT : BLANK_SEG);
        w_seg[1] = seg_of(r_s4.d1);
        w_seg[0] = seg_of(w_d0);
        if (r_s4.kind == KIND_SIGNED) begin
            if (r_s4.neg) begin
                if (r_s4.d2 != 4'd0) begin
                    w_seg[3] = DASH_SEG;
                end else if (r_s4.d1 != 4'd0) begin
                    w_seg[3] = BLANK_SEG;
                    w_seg[2] = DASH_SEG;
                end else begin
                    w_seg[3] = BLANK_SEG;
                    w_seg[2] = BLANK_SEG;
                    w_seg[1] = DASH_SEG;
                end
            end else begin
                if (r_s4.d3 == 4'd0) begin
                    w_seg[3] = BLANK_SEG;
                end
                if (r_s4.d3 == 4'd0 && r_s4.d2 == 4'd0) begin
                    w_seg[2] = BLANK_SEG;
                end
                if (r_s4.d3 == 4'd0 && r_s4.d2 == 4'd0 && r_s4.d1 == 4'd0) begin
                    w_seg[1] = BLANK_SEG;
                end
            end
        end
    end

    // Build the job record from the last stage.
    always_comb begin
        o_job = '0;
        unique case (r_s4.kind)
            KIND_DIGITS, KIND_SIGNED: begin
                o_job.last_idx   = 3'd4;
                o_job.bytes      = {w_seg[0], w_seg[1], w_seg[2], w_seg[3], ADDR_CMD};
                o_job.start_mask = 5'b00001;
                o_job.end_mask   = 5'b10000;
            end
            KIND_CMD1: begin
                o_job.last_idx   = 3'd0;
                o_job.bytes[0]   = r_s4.cmd0;
                o_job.start_mask = 5'b00001;
                o_job.end_mask   = 5'b00001;
            end
            KIND_CMD2: begin
                o_job.last_idx   = 3'd1;
                o_job.bytes[0]   = r_s4.cmd0;
                o_job.bytes[1]   = r_s4.cmd1;
                o_job.start_mask = 5'b00011;
                o_job.end_mask   = 5'b00011;
            end
            default: begin
                o_job = '0;
            end
        endcase
    end

    // Stage occupancy follows the handshake chain.
    always_comb begin
        n_v1 = w_can1 ? (w_accept && w_keep) : r_v1;
        n_v2 = w_can2 ? w_adv1 : r_v2;
        n_v3 = w_can3 ? w_adv2 : r_v3;
        n_v4 = w_can4 ? w_adv3 : r_v4;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_level <= RESET_LEVEL;
        end else begin
            r_v1    <= n_v1;
            r_v2    <= n_v2;
            r_v3    <= n_v3;
            r_v4    <= n_v4;
            r_level <= n_level;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_keep) begin
            r_s1 <= n_s1;
        end
        if (w_adv1) begin
            r_s2 <= n_s2;
        end
        if (w_adv2) begin
            r_s3 <= n_s3;
        end
        if (w_adv3) begin
            r_s4 <= n_s4;
        end
    end

endmodule

// ===== rtl/core/ffmt_queue.sv =====
// ============================================================================
// ffmt_queue: job queue between front end and byte sequencer
// A small circular buffer of job records so each side can stall on its own.
// ============================================================================
module ffmt_queue
    import ffmt_pkg::*;
#(
    parameter int Depth = FFMT_QUEUE_DEPTH
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_head
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(Depth - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(Depth);

    t_job            r_mem [Depth];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Pointer wrap and occupancy.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // The queue is never pushed when full nor popped when empty.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("job queue pushed while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("job queue popped while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("job queue count out of range");

endmodule

// ===== rtl/core/ffmt_back.sv =====
// ============================================================================
// ffmt_back: byte sequencer
// Takes job records from the queue and sends their bytes one per cycle, unless the output
// is stalled, through an output register, marking frame boundaries and the final byte.
// ============================================================================
module ffmt_back
    import ffmt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_job      i_head,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_item o_data,
    input  logic      i_stall
);

    t_job       r_job;
    logic       r_busy, n_busy;
    logic [2:0] r_idx, n_idx;
    logic       r_ovalid, n_ovalid;
    t_out_item  r_out, n_out;
    logic       w_emit, w_done;

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // A byte is sent when the output register is free or being drained.
    assign w_emit = r_busy && (!r_ovalid || !i_stall);
    assign w_done = w_emit && (r_idx == r_job.last_idx);
    assign o_pop  = (!r_busy || w_done) && !i_empty;

    // Next byte, sequencer position and output occupancy.
    always_comb begin
        n_out             = r_out;
        n_out.wire_byte   = r_job.bytes[r_idx];
        n_out.frame_start = r_job.start_mask[r_idx];
        n_out.frame_end   = r_job.end_mask[r_idx];
        n_out.last        = (r_idx == r_job.last_idx);
        n_ovalid          = w_emit ? 1'b1 : (i_stall ? r_ovalid : 1'b0);
        n_busy            = o_pop ? 1'b1 : (w_done ? 1'b0 : r_busy);
        n_idx             = o_pop ? 3'd0 : (w_emit ? r_idx + 3'd1 : r_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= 3'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
    end

    // Job and output payloads.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
        if (w_emit) begin
            r_out <= n_out;
        end
    end

    // The final byte of a request always closes its frame.
    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_out.last |-> r_out.frame_end)
        else $error("final byte without frame end");

    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx <= r_job.last_idx)
        else $error("sequencer position past end of job");

    a_display_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_out.frame_start && !r_out.frame_end |-> r_out.wire_byte == ADDR_CMD)
        else $error("open frame does not begin with the address command");

endmodule

// ===== rtl/core/four_digit_led_frame_formatter_unit.sv =====
// A request passes the four front stages, the job queue, the job register and the output
// register before its first byte shows on o_data. The byte sequencer sends one byte per cycle
// while i_stall is low; a display request gives five bytes, brightness or off one, init two.
// The front end takes a new request every cycle while its four stages and the job queue drain.
// Reset empties the stages, the queue and the output register and sets brightness to level 2.
// ============================================================================
// four_digit_led_frame_formatter_unit: LED driver frame formatter top level
// Turns display and control requests into command and segment bytes with
// frame start/stop marks, for a downstream two-wire pin serializer.
// ============================================================================
module four_digit_led_frame_formatter_unit
    import ffmt_pkg::*;
#(
    parameter int QueueDepth = FFMT_QUEUE_DEPTH
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_data,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_item o_data,
    input  logic      i_stall
);

    t_job w_push_job;
    t_job w_head;
    logic w_push, w_full, w_pop, w_empty;

    // Intake, classification and digit extraction.
    ffmt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_push  (w_push),
        .o_job   (w_push_job),
        .i_full  (w_full)
    );

    // Decoupling queue of jobs.
    ffmt_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    // Byte sequencer with output register.
    ffmt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top: testbench of the four-digit LED frame formatter
// Sends display, brightness, off and init requests through the valid/stall
// input channel and checks every command and segment byte on the output
// channel against an in-testbench prediction of the frame contents.
// Both channels idle at random, and one phase holds the output off long
// enough to back the block up into its input.
// ============================================================================
module tb_top;
    import ffmt_pkg::*;

    // The one selector value that the package leaves unnamed.
    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam int RESET_CYCLES   = 11;
    localparam int HOLD_CYCLES    = 160;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    t_in_item  i_data;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_data;
    logic      i_stall;

    // Predicted bytes in output order, and the predicted brightness.
    t_out_item  pending_bytes[$];
    logic [2:0] model_level;

    int error_count;
    int idle_cycles;
    int quiet_left;
    int hold_reqs;
    int hold_acks;

    four_digit_led_frame_formatter_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Records a failure; only the first few are described.
    task automatic log_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("tb_top: %s", msg);
        end
    endtask

    // Segment pattern of one decimal digit.
    function automatic logic [7:0] digit_segments(input int d);
        logic [7:0] s;
        case (d)
            0: s = 8'h3F;
            1: s = 8'h06;
            2: s = 8'h5B;
            3: s = 8'h4F;
            4: s = 8'h66;
            5: s = 8'h6D;
            6: s = 8'h7D;
            7: s = 8'h07;
            8: s = 8'h7F;
            default: s = 8'h6F;
        endcase
        return s;
    endfunction

    function automatic void push_byte(input logic [7:0] b, input logic st,
                                      input logic en, input logic ls);
        t_out_item r;
        r.wire_byte   = b;
        r.frame_start = st;
        r.frame_end   = en;
        r.last        = ls;
        pending_bytes.push_back(r);
    endfunction

    // Address command followed by the four digits, leftmost first.
    function automatic void push_display(input logic [7:0] s0, input logic [7:0] s1,
                                         input logic [7:0] s2, input logic [7:0] s3);
        push_byte(ADDR_CMD, 1'b1, 1'b0, 1'b0);
        push_byte(s0, 1'b0, 1'b0, 1'b0);
        push_byte(s1, 1'b0, 1'b0, 1'b0);
        push_byte(s2, 1'b0, 1'b0, 1'b0);
        push_byte(s3, 1'b0, 1'b1, 1'b1);
    endfunction

    // Works out the frame bytes of one accepted request.
    function automatic void predict_frame(input t_in_item req);
        int         v;
        int         mag;
        int         lvl;
        logic       neg;
        logic [7:0] s[4];
        v = int'(req.value);
        if (v > 9999) begin
            v = 9999;
        end
        case (req.op)
            OP_UNSIGNED, OP_COLON: begin
                s[0] = digit_segments((v / 1000) % 10);
                s[1] = digit_segments((v / 100) % 10);
                s[2] = digit_segments((v / 10) % 10);
                s[3] = digit_segments(v % 10);
                if (req.op == OP_COLON) begin
                    s[1] = s[1] | POINT_BIT;
                end
                push_display(s[0], s[1], s[2], s[3]);
            end
            OP_TIME: begin
                // Seconds on the left two digits, centiseconds on the right.
                s[0] = digit_segments((v / 100) / 10);
                s[1] = digit_segments((v / 100) % 10) | POINT_BIT;
                s[2] = digit_segments((v % 100) / 10);
                s[3] = digit_segments(v % 100);
                s[3] = digit_segments((v % 100) % 10);
                push_display(s[0], s[1], s[2], s[3]);
            end
            OP_SIGNED: begin
                neg = req.value[15];
                mag = neg ? 65536 - int'(req.value) : int'(req.value);
                if (neg && mag > 999) begin
                    mag = 999;
                end
                if (!neg && mag > 9999) begin
                    mag = 9999;
                end
                s[0] = digit_segments((mag / 1000) % 10);
                s[1] = digit_segments((mag / 100) % 10);
                s[2] = digit_segments((mag / 10) % 10);
                s[3] = digit_segments(mag % 10);
                if (neg) begin
                    // The dash sits just left of the top nonzero digit.
                    if (mag >= 100) begin
                        s[0] = DASH_SEG;
                    end else if (mag >= 10) begin
                        s[0] = BLANK_SEG;
                        s[1] = DASH_SEG;
                    end else begin
                        s[0] = BLANK_SEG;
                        s[1] = BLANK_SEG;
                        s[2] = DASH_SEG;
                    end
                end else begin
                    if (mag < 1000) s[0] = BLANK_SEG;
                    if (mag < 100)  s[1] = BLANK_SEG;
                    if (mag < 10)   s[2] = BLANK_SEG;
                end
                push_display(s[0], s[1], s[2], s[3]);
            end
            OP_OFF: begin
                push_byte(DISP_CMD | {5'd0, model_level}, 1'b1, 1'b1, 1'b1);
            end
            OP_BRIGHT: begin
                lvl = int'(req.value);
                if (lvl > 7) begin
                    lvl = 7;
                end
                model_level = 3'(lvl);
                push_byte(DISP_CMD | DISP_ON | {5'd0, model_level}, 1'b1, 1'b1, 1'b1);
            end
            OP_INIT: begin
                push_byte(DATA_CMD, 1'b1, 1'b1, 1'b0);
                push_byte(DISP_CMD | DISP_ON | {5'd0, model_level}, 1'b1, 1'b1, 1'b1);
            end
            default: begin
                // The unused selector gives nothing and changes nothing.
            end
        endcase
    endfunction

    // Sender idle length: mostly none, some short, a few long, with quiet runs.
    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if (r < 5) begin
            quiet_left = $urandom_range(10, 30);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offers one item after an idle gap and waits until it is taken.
    task automatic send_request(input logic [2:0] op, input logic [15:0] value,
                                input int gap);
        t_in_item req;
        t_in_item noise;
        req.op    = op;
        req.value = value;
        repeat (gap) begin
            @(negedge i_clk);
            noise.op    = 3'($urandom);
            noise.value = 16'($urandom);
            i_valid <= 1'b0;
            i_data  <= noise;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data  <= req;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        predict_frame(req);
    endtask

    // Field extremes, every operation and each saturation and blanking case.
    task automatic test_directed_cases();
        send_request(OP_UNSIGNED, 16'd0, 0);
        send_request(OP_UNSIGNED, 16'd9999, 0);
        send_request(OP_UNSIGNED, 16'd10000, 1);
        send_request(OP_UNSIGNED, 16'hFFFF, 0);
        send_request(OP_TIME, 16'd0, 0);
        send_request(OP_TIME, 16'd1234, 2);
        send_request(OP_TIME, 16'hFFFF, 0);
        send_request(OP_COLON, 16'd5678, 0);
        send_request(OP_SIGNED, 16'd0, 0);
        send_request(OP_SIGNED, 16'd7, 3);
        send_request(OP_SIGNED, 16'd45, 0);
        send_request(OP_SIGNED, 16'd123, 0);
        send_request(OP_SIGNED, 16'h7FFF, 0);
        send_request(OP_SIGNED, 16'hFFFF, 0);
        send_request(OP_SIGNED, 16'hFFD3, 1);
        send_request(OP_SIGNED, 16'hFC19, 0);
        send_request(OP_SIGNED, 16'hFC18, 0);
        send_request(OP_SIGNED, 16'h8000, 0);
        send_request(OP_OFF, 16'd0, 0);
        send_request(OP_INIT, 16'd0, 4);
        send_request(OP_BRIGHT, 16'd8, 0);
        send_request(OP_BRIGHT, 16'd0, 0);
        send_request(OP_OFF, 16'hFFFF, 0);
        send_request(OP_BRIGHT, 16'hFFFF, 0);
        send_request(OP_UNUSED, 16'hA5A5, 0);
    endtask

    function automatic logic [15:0] random_value();
        case ($urandom_range(0, 9))
            0, 1, 2: return 16'($urandom_range(0, 65535));
            3, 4:    return 16'($urandom_range(0, 9999));
            5:       return 16'($urandom_range(9995, 10005));
            6:       return 16'($urandom_range(0, 120));
            7:       return 16'(65536 - $urandom_range(1, 1100));
            default: return 16'($urandom_range(0, 10));
        endcase
    endfunction

    function automatic logic [2:0] random_op();
        if ($urandom_range(0, 99) < 3) begin
            return OP_UNUSED;
        end
        return 3'($urandom_range(0, 6));
    endfunction

    // The output is held off for a long stretch while items keep coming.
    task automatic test_backpressure_fill();
        hold_reqs++;
        repeat (25) begin
            send_request(3'($urandom_range(0, 6)), random_value(), 0);
        end
    endtask

    // Random requests with random idling on both sides.
    task automatic test_random_requests();
        int         sent;
        logic [2:0] op;
        sent = 0;
        while (sent < 175) begin
            op = random_op();
            send_request(op, random_value(), next_gap());
            if (op != OP_UNUSED) begin
                sent++;
            end
        end
    endtask

    // Receiver stall: random runs, plus the long hold when one is requested.
    initial begin : drive_output_stall
        int stall_left;
        int run_left;
        int r;
        stall_left = 0;
        run_left   = 0;
        i_stall    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_reqs != hold_acks) begin
                hold_acks++;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                if (stall_left == 0 && run_left == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 10) begin
                        run_left = $urandom_range(20, 60);
                    end else if (r < 15) begin
                        stall_left = $urandom_range(10, 40);
                    end else if (r < 50) begin
                        stall_left = $urandom_range(1, 3);
                    end else begin
                        run_left = $urandom_range(1, 4);
                    end
                end
                if (stall_left > 0) begin
                    i_stall <= 1'b1;
                    stall_left--;
                end else begin
                    i_stall <= 1'b0;
                    run_left--;
                end
            end
        end
    end

    // Each accepted byte is matched against the oldest prediction.
    always @(posedge i_clk) begin : check_bytes
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_bytes.size() == 0) begin
                log_error($sformatf("unexpected byte %02h start %b end %b last %b",
                                    o_data.wire_byte, o_data.frame_start,
                                    o_data.frame_end, o_data.last));
            end else begin
                want = pending_bytes.pop_front();
                if (o_data.wire_byte !== want.wire_byte ||
                    o_data.frame_start !== want.frame_start ||
                    o_data.frame_end !== want.frame_end ||
                    o_data.last !== want.last) begin
                    log_error($sformatf(
                        "byte mismatch: expected %02h/%b/%b/%b got %02h/%b/%b/%b",
                        want.wire_byte, want.frame_start, want.frame_end, want.last,
                        o_data.wire_byte, o_data.frame_start, o_data.frame_end,
                        o_data.last));
                end
            end
        end
    end

    // Watchdog: ends the run when no item moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        model_level = RESET_LEVEL;
        error_count = 0;
        idle_cycles = 0;
        quiet_left  = 0;
        hold_reqs   = 0;
        hold_acks   = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_backpressure_fill();
        test_random_requests();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_bytes.size() != 0) begin
            log_error($sformatf("%0d bytes never arrived", pending_bytes.size()));
        end

        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
